@@ src/pal_pkg.sv @@
// Shared types and constants for the PIN attempt lockout block.
// Used by pal_ctrl, pal_datapath and pin_attempt_lockout_core; depends on nothing.
package pal_pkg;

    localparam int FAIL_SLOTS = 32;
    localparam int SLOT_W     = (FAIL_SLOTS > 1) ? $clog2(FAIL_SLOTS) : 1;

    localparam int PIN_W      = 32;
    localparam int KEY_W      = 16;
    localparam int WAIT_W     = 30;
    localparam int LIMIT_W    = 5;

    localparam logic [PIN_W-1:0]   ALL_ONES      = '1;
    localparam logic [WAIT_W-1:0]  WAIT_MAX      = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 5'd15;
    localparam logic [PIN_W-1:0]   DEFAULT_PIN   = 32'h0000_0001;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_UNLOCK = 3'd1,
        OP_CHANGE = 3'd2,
        OP_TICK   = 3'd3,
        OP_KEY    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DENIED    = 3'd1,
        ST_WAITING   = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_HALTED    = 3'd4,
        ST_IDLE_TICK = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_UNLOCK = 2'd1,
        PEND_CHANGE = 2'd2
    } pend_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // load the input request registers
        logic execute;   // apply the request and load the result registers
    } pal_cmd_t;

endpackage

@@ src/pal_ctrl.sv @@
// Request sequencer for the PIN attempt lockout block.
// Depends on pal_pkg; drives the handshakes and commands the datapath.
module pal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pal_pkg::pal_cmd_t cmd
);
    import pal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.execute = (state_reg == S_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A captured request is executed next, never dropped.
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("captured request did not move to execute");

    // Executing a request always presents a result on the next cycle.
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid_reg)
        else $error("executed request produced no result");

    // Only one request is in flight: no capture while executing.
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

@@ src/pal_datapath.sv @@
// Datapath of the PIN attempt lockout block: request registers, guard state,
// failure word arithmetic and result registers. Depends on pal_pkg.
module pal_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pal_pkg::pal_cmd_t             cmd,
    input  logic                          cfg_valid,
    input  logic [pal_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic [2:0]                    op,
    input  logic [pal_pkg::PIN_W-1:0]     pin,
    input  logic [pal_pkg::PIN_W-1:0]     new_pin,
    input  logic [pal_pkg::KEY_W-1:0]     key,
    output logic [2:0]                    status,
    output logic [pal_pkg::WAIT_W-1:0]    wait_left,
    output logic [pal_pkg::WAIT_W-1:0]    wait_total,
    output logic                          is_unlocked,
    output logic                          has_pin
);
    import pal_pkg::*;

    // Request registers (payload, no reset).
    logic [2:0]       op_reg;
    logic [PIN_W-1:0] pin_reg;
    logic [PIN_W-1:0] new_pin_reg;
    logic [KEY_W-1:0] key_reg;

    // Guard state.
    logic [LIMIT_W-1:0] fail_limit_reg;
    logic               ready_reg, ready_next;
    logic               open_reg, open_next;
    logic               halted_reg, halted_next;
    logic               present_reg, present_next;
    logic [PIN_W-1:0]   stored_pin_reg, stored_pin_next;
    logic [PIN_W-1:0]   fail_word_reg, fail_word_next;
    logic [SLOT_W-1:0]  fail_slot_reg, fail_slot_next;
    logic [WAIT_W-1:0]  wait_count_reg, wait_count_next;
    pend_t              pend_reg, pend_next;
    logic [PIN_W-1:0]   pend_pin_reg, pend_pin_next;
    logic [PIN_W-1:0]   pend_npin_reg, pend_npin_next;

    // Result registers.
    logic [2:0]        status_reg;
    logic [WAIT_W-1:0] wait_left_reg;
    logic [WAIT_W-1:0] wait_total_reg;
    logic              unlocked_reg;
    logic              has_pin_reg;

    // Failure word arithmetic.
    logic [PIN_W-1:0]  inv_word;
    logic [PIN_W-1:0]  shifted_word;
    logic [PIN_W-1:0]  limit_val;
    logic              over_now;
    logic              over_shifted;
    logic [WAIT_W-1:0] wait_now;
    logic [WAIT_W-1:0] wait_dec;

    // Attempt evaluation.
    status_t           st;
    logic [WAIT_W-1:0] wl;
    logic [WAIT_W-1:0] wt;
    logic              do_start;
    logic              do_check;
    logic              do_wipe;
    pend_t             kind;
    logic [PIN_W-1:0]  chk_pin;
    logic [PIN_W-1:0]  chk_npin;
    logic              match;

    assign inv_word     = ~fail_word_reg;
    assign shifted_word = {fail_word_reg[PIN_W-2:0], 1'b0};
    assign limit_val    = PIN_W'(1) << fail_limit_reg;
    assign over_now     = inv_word >= limit_val;
    assign over_shifted = ~shifted_word >= limit_val;
    assign wait_now     = (|inv_word[PIN_W-1:WAIT_W]) ? WAIT_MAX : inv_word[WAIT_W-1:0];
    assign wait_dec     = wait_count_reg - WAIT_W'(1);

    // A tick that ends the wait checks the held request, otherwise the fresh one.
    assign chk_pin  = (op_reg == OP_TICK) ? pend_pin_reg  : pin_reg;
    assign chk_npin = (op_reg == OP_TICK) ? pend_npin_reg : new_pin_reg;
    assign match    = present_reg ? (chk_pin == stored_pin_reg) : (chk_pin == DEFAULT_PIN);

    always_comb
    begin
        ready_next      = ready_reg;
        open_next       = open_reg;
        halted_next     = halted_reg;
        present_next    = present_reg;
        stored_pin_next = stored_pin_reg;
        fail_word_next  = fail_word_reg;
        fail_slot_next  = fail_slot_reg;
        wait_count_next = wait_count_reg;
        pend_next       = pend_reg;
        pend_pin_next   = pend_pin_reg;
        pend_npin_next  = pend_npin_reg;
        st              = ST_NOT_READY;
        wl              = '0;
        wt              = '0;
        do_start        = 1'b0;
        do_check        = 1'b0;
        do_wipe         = 1'b0;
        kind            = PEND_NONE;

        if (op_reg == OP_INIT)
        begin
            ready_next      = 1'b1;
            open_next       = 1'b0;
            halted_next     = 1'b0;
            pend_next       = PEND_NONE;
            wait_count_next = '0;
            st              = ST_OK;
        end
        else if (halted_reg)
        begin
            st = ST_HALTED;
        end
        else if ((op_reg == OP_UNLOCK || op_reg == OP_CHANGE) && pend_reg != PEND_NONE)
        begin
            // A new attempt while one is waiting is refused.
            st = ST_WAITING;
            wl = wait_count_reg;
            wt = wait_now;
        end
        else
        begin
            case (op_reg)
                OP_UNLOCK:
                begin
                    open_next = 1'b0;
                    if (ready_reg)
                    begin
                        do_start = 1'b1;
                        kind     = PEND_UNLOCK;
                    end
                end
                OP_CHANGE:
                begin
                    if (ready_reg && open_reg)
                    begin
                        do_start = 1'b1;
                        kind     = PEND_CHANGE;
                    end
                end
                OP_TICK:
                begin
                    if (pend_reg == PEND_NONE)
                    begin
                        st = ST_IDLE_TICK;
                    end
                    else
                    begin
                        wait_count_next = wait_dec;
                        if (wait_dec == '0)
                        begin
                            kind      = pend_reg;
                            pend_next = PEND_NONE;
                            do_check  = 1'b1;
                        end
                        else
                        begin
                            st = ST_WAITING;
                            wl = wait_dec;
                            wt = wait_now;
                        end
                    end
                end
                OP_KEY:
                begin
                    st = (ready_reg && open_reg && (|key_reg[KEY_W-1:8])) ? ST_OK : ST_DENIED;
                end
                default:
                begin
                    st = ST_NOT_READY;
                end
            endcase
        end

        // Starting an attempt: wipe at the limit, check at once with no backoff,
        // otherwise hold the request until the backoff runs out.
        if (do_start)
        begin
            if (over_now)
            begin
                do_wipe = 1'b1;
            end
            else if (inv_word == '0)
            begin
                do_check = 1'b1;
            end
            else
            begin
                pend_next       = kind;
                pend_pin_next   = pin_reg;
                pend_npin_next  = new_pin_reg;
                wait_count_next = wait_now;
                st              = ST_WAITING;
                wl              = wait_now;
                wt              = wait_now;
            end
        end

        // The failure is counted before the compare, and erased on a match.
        if (do_check)
        begin
            fail_word_next = shifted_word;
            if (!match)
            begin
                if (over_shifted)
                begin
                    do_wipe = 1'b1;
                end
                else
                begin
                    st = ST_DENIED;
                end
            end
            else
            begin
                fail_word_next = ALL_ONES;
                fail_slot_next = (fail_slot_reg == SLOT_W'(FAIL_SLOTS - 1))
                               ? '0 : fail_slot_reg + SLOT_W'(1);
                if (kind == PEND_UNLOCK)
                begin
                    open_next = 1'b1;
                end
                else
                begin
                    stored_pin_next = chk_npin;
                    present_next    = 1'b1;
                end
                st = ST_OK;
            end
        end

        if (do_wipe)
        begin
            present_next    = 1'b0;
            stored_pin_next = '0;
            fail_word_next  = ALL_ONES;
            fail_slot_next  = '0;
            open_next       = 1'b0;
            pend_next       = PEND_NONE;
            wait_count_next = '0;
            halted_next     = 1'b1;
            st              = ST_HALTED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            pin_reg     <= pin;
            new_pin_reg <= new_pin;
            key_reg     <= key;
        end
        if (cmd.execute)
        begin
            status_reg     <= st;
            wait_left_reg  <= wl;
            wait_total_reg <= wt;
            unlocked_reg   <= open_next;
            has_pin_reg    <= present_next && ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg <= LIMIT_RESET;
            ready_reg      <= 1'b0;
            open_reg       <= 1'b0;
            halted_reg     <= 1'b0;
            present_reg    <= 1'b0;
            stored_pin_reg <= '0;
            fail_word_reg  <= ALL_ONES;
            fail_slot_reg  <= '0;
            wait_count_reg <= '0;
            pend_reg       <= PEND_NONE;
            pend_pin_reg   <= '0;
            pend_npin_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fail_limit_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                ready_reg      <= ready_next;
                open_reg       <= open_next;
                halted_reg     <= halted_next;
                present_reg    <= present_next;
                stored_pin_reg <= stored_pin_next;
                fail_word_reg  <= fail_word_next;
                fail_slot_reg  <= fail_slot_next;
                wait_count_reg <= wait_count_next;
                pend_reg       <= pend_next;
                pend_pin_reg   <= pend_pin_next;
                pend_npin_reg  <= pend_npin_next;
            end
        end
    end

    assign status      = status_reg;
    assign wait_left   = wait_left_reg;
    assign wait_total  = wait_total_reg;
    assign is_unlocked = unlocked_reg;
    assign has_pin     = has_pin_reg;

    // The failure word only ever loses ones from the bottom.
    a_fail_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_word & (inv_word + PIN_W'(1))) == '0)
        else $error("failure word is not a run of cleared low bits");

    // A waiting attempt always has backoff time left.
    a_pending_has_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != PEND_NONE) |-> (wait_count_reg != '0))
        else $error("attempt pending with zero backoff");

    // A wiped block holds nothing pending and is locked.
    a_halted_clean: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (pend_reg == PEND_NONE && !open_reg))
        else $error("halted block is unlocked or has a pending attempt");

endmodule

@@ src/pin_attempt_lockout_core.sv @@
// PIN attempt lockout with exponential backoff and wipe: top level.
// Depends on pal_pkg, pal_ctrl and pal_datapath.
//
// This block guards a stored PIN. Each request carries an op (init, unlock
// attempt, change PIN, one-second tick, key access check) and gets exactly one
// result. Failures are counted in a word that starts at all ones and loses one
// low bit per failure; before every attempt the caller must deliver as many
// tick requests as the inverted word holds, and each tick reports the seconds
// left. The PIN is compared only when the wait is over, and the failure is
// counted before the compare, so cutting power mid-check gains nothing. With no
// PIN stored, the PIN value 1 is accepted. When the inverted failure word
// reaches 2 to the power fail_limit, the stored PIN and counters are wiped and
// every request but init answers "halted". The single configuration register,
// fail_limit, is written through the cfg channel, which is always ready; write
// it only while no request is in flight. Each request is first captured in the
// input register, and then the datapath applies it to the guard state and
// loads the output register. A result that is held off by out_stall does not
// block the next request from being captured, but that request waits in the
// execute step until the output register frees up. There is no clearing pass
// after reset.
module pin_attempt_lockout_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    op,
    input  logic [pal_pkg::PIN_W-1:0]     pin,
    input  logic [pal_pkg::PIN_W-1:0]     new_pin,
    input  logic [pal_pkg::KEY_W-1:0]     key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [pal_pkg::WAIT_W-1:0]    wait_left,
    output logic [pal_pkg::WAIT_W-1:0]    wait_total,
    output logic                          is_unlocked,
    output logic                          has_pin,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pal_pkg::LIMIT_W-1:0]   cfg_data
);
    import pal_pkg::*;

    pal_cmd_t cmd;

    // The register write never has to wait.
    assign cfg_ready = 1'b1;

    // The controller sequences capture and execute and owns the result valid.
    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath holds the guard state and the result fields.
    pal_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .op          (op),
        .pin         (pin),
        .new_pin     (new_pin),
        .key         (key),
        .status      (status),
        .wait_left   (wait_left),
        .wait_total  (wait_total),
        .is_unlocked (is_unlocked),
        .has_pin     (has_pin)
    );

endmodule
